FILE: rtl/core/cba_pkg.sv
// shared types and constants of the contiguous block allocator
package cba_pkg;

   // width of a block count derived from a 16-bit byte size
   localparam int NEED_W = 16;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // block count from the size divider
   typedef struct packed {
      logic              done;
      logic [NEED_W-1:0] blocks;
   } need_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_MARK,
      ST_FREE_READ,
      ST_FREE_CHECK,
      ST_RELEASE
   } state_type;

endpackage

FILE: rtl/core/cba_ram.sv
// generic single-write, single-read ram with registered read data
module cba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cba_size_div.sv
// pipelined ceil(size / BLOCK_BYTES) by reciprocal multiply and one correction
module cba_size_div #(
   parameter int BLOCK_BYTES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [15:0]      req_size,
   output cba_pkg::need_type result
);
   import cba_pkg::*;

   localparam int SUM_W   = $clog2(65535 + BLOCK_BYTES);
   localparam int RECIP_W = SUM_W + 1;
   localparam int BB_W    = $clog2(BLOCK_BYTES + 1);
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam int QD_W    = SUM_W + BB_W;
   localparam longint unsigned RECIP = (longint'(1) << SUM_W) / BLOCK_BYTES;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
   localparam logic [BB_W-1:0]    BB_C    = BB_W'(BLOCK_BYTES);

   logic              v1_ff, v2_ff, v3_ff, v4_ff, done_ff;
   logic [SUM_W-1:0]  x1_ff, x2_ff, x3_ff, x4_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  q3_ff, q4_ff;
   logic [QD_W-1:0]   qd_ff;
   logic [NEED_W-1:0] blocks_ff;
   logic [SUM_W-1:0]  rem;
   logic              bump;

   // remainder after the estimate; the estimate is low by at most one
   assign rem  = x4_ff - SUM_W'(qd_ff);
   assign bump = 32'(rem) >= 32'(BLOCK_BYTES);

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         v4_ff   <= v3_ff;
         done_ff <= v4_ff;
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      x1_ff     <= SUM_W'(req_size) + SUM_W'(BLOCK_BYTES - 1);
      prod_ff   <= PROD_W'(x1_ff) * PROD_W'(RECIP_C);
      x2_ff     <= x1_ff;
      q3_ff     <= prod_ff[SUM_W +: SUM_W];
      x3_ff     <= x2_ff;
      qd_ff     <= QD_W'(q3_ff) * QD_W'(BB_C);
      q4_ff     <= q3_ff;
      x4_ff     <= x3_ff;
      blocks_ff <= bump ? NEED_W'(q4_ff) + NEED_W'(1) : NEED_W'(q4_ff);
   end

   assign result.done   = done_ff;
   assign result.blocks = blocks_ff;

endmodule

FILE: rtl/core/cba_engine.sv
// sequencer: clearing pass, first-fit scan, run marking and release over the block table
module cba_engine #(
   parameter int NUM_BLOCKS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_kind,
   input  logic [5:0]                        req_block_index,
   output logic                              div_start,
   input  cba_pkg::need_type                 div_result,
   output logic                              mem_wr_en,
   output logic [$clog2(NUM_BLOCKS)-1:0]     mem_wr_addr,
   output logic [$clog2(NUM_BLOCKS+1):0]     mem_wr_data,
   output logic [$clog2(NUM_BLOCKS)-1:0]     mem_rd_addr,
   input  logic [$clog2(NUM_BLOCKS+1):0]     mem_rd_data,
   output logic                              rsp_valid,
   output logic                              rsp_success,
   output logic [5:0]                        rsp_result_block,
   output logic [6:0]                        rsp_free_count
);
   import cba_pkg::*;

   localparam int AW    = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int EW    = CNT_W + 1;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic [CNT_W-1:0] need_ff, need_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] free_ff, free_in;
   logic [AW-1:0]    proc_ff, proc_in;
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    start_blk_ff, start_blk_in;
   logic             pending_ff, pending_in;
   logic             first_ff, first_in;
   logic [5:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_success_ff, rsp_success_in;
   logic [5:0]       rsp_block_ff, rsp_block_in;
   logic [6:0]       rsp_free_ff, rsp_free_in;

   logic              accept;
   logic              rd_used;
   logic [CNT_W-1:0]  rd_len;
   logic [NEED_W-1:0] need_adj;
   logic              too_big;
   logic              scan_end;
   logic              hit;
   logic              idx_bad;
   logic              free_ok;
   logic              last_write;
   logic [CNT_W:0]    start_wide;

   // decode of the table entry and the current request
   assign accept     = start && (state_ff == ST_IDLE);
   assign rd_used    = mem_rd_data[EW-1];
   assign rd_len     = mem_rd_data[CNT_W-1:0];
   assign need_adj   = (div_result.blocks == '0) ? NEED_W'(1) : div_result.blocks;
   assign too_big    = 32'(need_adj) > 32'(NUM_BLOCKS);
   assign scan_end   = !pending_ff && (iss_ff == CNT_W'(NUM_BLOCKS));
   assign hit        = pending_ff && !rd_used && (CNT_W'(run_ff + 1'b1) == need_ff);
   assign idx_bad    = 32'(idx_ff) >= 32'(NUM_BLOCKS);
   assign free_ok    = rd_used && (rd_len != '0);
   assign last_write = (left_ff == CNT_W'(1));
   assign start_wide = (CNT_W+1)'(proc_ff) + (CNT_W+1)'(1) - (CNT_W+1)'(need_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (last_write) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = (req_kind == KIND_FREE) ? ST_FREE_READ : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_result.done) state_in = too_big ? ST_IDLE : ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_MARK;
            end else if (scan_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_MARK: begin
            if (last_write) state_in = ST_IDLE;
         end
         ST_FREE_READ: begin
            state_in = idx_bad ? ST_IDLE : ST_FREE_CHECK;
         end
         ST_FREE_CHECK: begin
            state_in = free_ok ? ST_RELEASE : ST_IDLE;
         end
         ST_RELEASE: begin
            if (last_write) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, table accesses and result
   always_comb begin
      iss_in         = iss_ff;
      run_in         = run_ff;
      need_in        = need_ff;
      left_in        = left_ff;
      free_in        = free_ff;
      proc_in        = proc_ff;
      wr_ptr_in      = wr_ptr_ff;
      start_blk_in   = start_blk_ff;
      pending_in     = 1'b0;
      first_in       = first_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_success_in = 1'b0;
      rsp_block_in   = 6'd0;
      rsp_free_in    = 7'(free_ff);
      div_start      = 1'b0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = wr_ptr_ff;
      mem_wr_data    = '0;
      mem_rd_addr    = iss_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            wr_ptr_in = wr_ptr_ff + 1'b1;
            left_in   = left_ff - 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               idx_in    = req_block_index;
               div_start = (req_kind == KIND_ALLOC);
            end
         end
         ST_DIVIDE: begin
            if (div_result.done) begin
               if (too_big) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  need_in = CNT_W'(need_adj);
                  iss_in  = '0;
                  run_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            // issue one read a cycle, judge the block read the cycle before
            if (iss_ff != CNT_W'(NUM_BLOCKS)) begin
               pending_in = 1'b1;
               proc_in    = iss_ff[AW-1:0];
               iss_in     = iss_ff + 1'b1;
            end
            if (pending_ff) begin
               run_in = rd_used ? '0 : CNT_W'(run_ff + 1'b1);
            end
            if (hit) begin
               start_blk_in = AW'(start_wide);
               wr_ptr_in    = AW'(start_wide);
               left_in      = need_ff;
               first_in     = 1'b1;
            end else if (scan_end) begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_MARK: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {1'b1, first_ff ? need_ff : CNT_W'(0)};
            first_in    = 1'b0;
            wr_ptr_in   = wr_ptr_ff + 1'b1;
            left_in     = left_ff - 1'b1;
            if (last_write) begin
               free_in        = free_ff - need_ff;
               rsp_valid_in   = 1'b1;
               rsp_success_in = 1'b1;
               rsp_block_in   = 6'(start_blk_ff);
               rsp_free_in    = 7'(free_ff - need_ff);
            end
         end
         ST_FREE_READ: begin
            mem_rd_addr = AW'(idx_ff);
            if (idx_bad) rsp_valid_in = 1'b1;
         end
         ST_FREE_CHECK: begin
            if (free_ok) begin
               wr_ptr_in = AW'(idx_ff);
               left_in   = rd_len;
               need_in   = rd_len;
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_RELEASE: begin
            mem_wr_en = 1'b1;
            wr_ptr_in = wr_ptr_ff + 1'b1;
            left_in   = left_ff - 1'b1;
            if (last_write) begin
               free_in        = free_ff + need_ff;
               rsp_valid_in   = 1'b1;
               rsp_success_in = 1'b1;
               rsp_free_in    = 7'(free_ff + need_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wr_ptr_ff    <= '0;
         left_ff      <= CNT_W'(NUM_BLOCKS);
         free_ff      <= CNT_W'(NUM_BLOCKS);
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         left_ff      <= left_in;
         free_ff      <= free_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      iss_ff         <= iss_in;
      run_ff         <= run_in;
      need_ff        <= need_in;
      proc_ff        <= proc_in;
      start_blk_ff   <= start_blk_in;
      first_ff       <= first_in;
      idx_ff         <= idx_in;
      rsp_success_ff <= rsp_success_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_free_ff    <= rsp_free_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_free_count   = rsp_free_ff;

endmodule

FILE: rtl/core/contiguous_block_allocator.sv
// Contiguous block allocator, first fit, over a pool of NUM_BLOCKS blocks.
// Request channel: req_kind (0 allocate, 1 free), req_request_size in bytes,
// req_block_index; a transfer happens at a rising edge with start high and
// busy low. Each request gives one result, shown for exactly one cycle with
// rsp_valid high: rsp_success, rsp_result_block and rsp_free_count (free
// blocks after the request). The receiver cannot stall; the result is taken
// in the cycle it is shown, and a new request may be issued in that cycle.
// Allocate: the byte size passes through the pipelined size divider, then a
// scan of the block table at one entry per cycle, then one block of the run
// is written per cycle. Free: the start entry is read and checked, then one
// block of the run is written per cycle.
// The single table ram port pair bounds both the scan and the writes.
// After reset a clearing pass writes every table entry with busy held high;
// then every block is free.
module contiguous_block_allocator #(
   parameter int NUM_BLOCKS  = 64,
   parameter int BLOCK_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [15:0] req_request_size,
   input  logic [5:0]  req_block_index,
   output logic        rsp_valid,
   output logic        rsp_success,
   output logic [5:0]  rsp_result_block,
   output logic [6:0]  rsp_free_count
);
   import cba_pkg::*;

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int EW = $clog2(NUM_BLOCKS + 1) + 1;

   need_type      div_result;
   logic          div_start;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [EW-1:0] mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   logic [EW-1:0] mem_rd_data;

   // block count from the byte size
   cba_size_div #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .req_size (req_request_size),
      .result   (div_result)
   );

   // block table: used mark and run length per block
   cba_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sequencer
   cba_engine #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_block_index  (req_block_index),
      .div_start        (div_start),
      .div_result       (div_result),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_success      (rsp_success),
      .rsp_result_block (rsp_result_block),
      .rsp_free_count   (rsp_free_count)
   );

   // a result is shown only once the sequencer is back to waiting
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer busy");

   // a result always ends a busy stretch
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding work");

   // no result in the cycle right after a transfer in
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result in cycle after request transfer");

   // failed requests report block zero
   a_fail_block_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_success) |-> (rsp_result_block == 6'd0))
      else $error("failed result with nonzero block");

endmodule

FILE: test/testbench.sv
// self-checking testbench of the first-fit contiguous block allocator
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cba_pkg::*;

   localparam int POOL_BLOCKS   = 64;
   localparam int BYTES_PER_BLK = 256;
   // settle allowance sized against the worst allocate and the longest sender gap
   localparam int SETTLE_CYCLES = 150;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 1100;

   typedef struct packed {
      logic       success;
      logic [5:0] start_block;
      logic [6:0] free_count;
   } alloc_outcome_type;

   // shadow of the block table plus the queue of outcomes still to arrive
   class alloc_scoreboard;
      bit                used_map[POOL_BLOCKS];
      bit [6:0]          run_len[POOL_BLOCKS];
      int                free_left;
      alloc_outcome_type outcome_q[$];
      int                errors;
      int                checked;
      int                alloc_ok;
      int                alloc_refused;
      int                free_ok;
      int                free_rejected;
      int                min_free;

      function new();
         foreach (used_map[i]) begin
            used_map[i] = 1'b0;
            run_len[i]  = '0;
         end
         free_left = POOL_BLOCKS;
         min_free  = POOL_BLOCKS;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      // start index of a random live run, -1 when the pool is empty
      function int pick_live_start();
         int starts[$];
         foreach (run_len[i])
            if (run_len[i] != 0) starts.push_back(i);
         if (starts.size() == 0) return -1;
         return starts[$urandom_range(starts.size() - 1)];
      endfunction

      // apply one accepted request to the shadow table, queue its outcome
      function void note_request(logic kind, logic [15:0] size, logic [5:0] idx);
         alloc_outcome_type res;
         int                need;
         int                base;
         int                k;
         bit                fits;
         res = '0;
         if (kind == KIND_ALLOC) begin
            need = (int'(size) + BYTES_PER_BLK - 1) / BYTES_PER_BLK;
            if (need == 0) need = 1;
            if (need <= POOL_BLOCKS) begin
               // first fit over runs that lie wholly inside the pool
               for (base = 0; base + need <= POOL_BLOCKS && !res.success; base++) begin
                  fits = 1'b1;
                  for (k = 0; k < need; k++)
                     if (used_map[base + k]) fits = 1'b0;
                  if (fits) begin
                     for (k = 0; k < need; k++) used_map[base + k] = 1'b1;
                     run_len[base]   = 7'(need);
                     free_left      -= need;
                     res.success     = 1'b1;
                     res.start_block = 6'(base);
                  end
               end
            end
            if (res.success) alloc_ok++;
            else alloc_refused++;
         end else begin
            // only the first block of a live run can be released
            if (used_map[idx] && run_len[idx] != 0) begin
               for (k = 0; k < run_len[idx] && idx + k < POOL_BLOCKS; k++) begin
                  if (used_map[idx + k]) begin
                     used_map[idx + k] = 1'b0;
                     free_left++;
                  end
               end
               run_len[idx] = '0;
               res.success  = 1'b1;
               free_ok++;
            end else begin
               free_rejected++;
            end
         end
         res.free_count = 7'(free_left);
         if (free_left < min_free) min_free = free_left;
         outcome_q.push_back(res);
      endfunction

      // compare one result transfer with the oldest queued outcome
      function void check_result(logic success, logic [5:0] blk, logic [6:0] cnt);
         alloc_outcome_type want;
         if (outcome_q.size() == 0) begin
            $display("%0t ERROR result with nothing pending: success %0d block %0d free %0d",
                     $time, success, blk, cnt);
            errors++;
            return;
         end
         want = outcome_q.pop_front();
         checked++;
         if (success !== want.success) begin
            $display("%0t ERROR success expected %0d actual %0d", $time, want.success, success);
            errors++;
         end
         if (blk !== want.start_block) begin
            $display("%0t ERROR result_block expected %0d actual %0d",
                     $time, want.start_block, blk);
            errors++;
         end
         if (cnt !== want.free_count) begin
            $display("%0t ERROR free_count expected %0d actual %0d",
                     $time, want.free_count, cnt);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = KIND_ALLOC;
   logic [15:0] req_request_size = '0;
   logic [5:0]  req_block_index = '0;
   logic        rsp_valid;
   logic        rsp_success;
   logic [5:0]  rsp_result_block;
   logic [6:0]  rsp_free_count;

   alloc_scoreboard sb;
   bit              burst;
   int              idle_cycles = 0;

   contiguous_block_allocator #(
      .NUM_BLOCKS  (POOL_BLOCKS),
      .BLOCK_BYTES (BYTES_PER_BLK)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_request_size (req_request_size),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_success      (rsp_success),
      .rsp_result_block (rsp_result_block),
      .rsp_free_count   (rsp_free_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_success, rsp_result_block, rsp_free_count);
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // hold a request until the block takes it
   task automatic send_item(input logic kind, input logic [15:0] size, input logic [5:0] idx);
      req_kind         <= kind;
      req_request_size <= size;
      req_block_index  <= idx;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(kind, size, idx);
   endtask

   // random pause between requests, mostly short, none in burst stretches
   task automatic sender_gap();
      int r;
      int gap;
      r = $urandom_range(99);
      if (burst || r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(30, 120);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every outstanding result has come back
   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic alloc(input logic [15:0] size);
      send_item(KIND_ALLOC, size, 6'($urandom_range(63)));
      sender_gap();
   endtask

   task automatic release_run(input logic [5:0] idx);
      send_item(KIND_FREE, 16'($urandom_range(65535)), idx);
      sender_gap();
   endtask

   // byte sizes: mostly a few blocks, sometimes the whole pool or beyond
   function automatic logic [15:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 16'($urandom_range(1024));
      if (r < 90) return 16'($urandom_range(4096));
      if (r < 97) return 16'($urandom_range(16384));
      return 16'($urandom_range(65535));
   endfunction

   initial begin
      int live;
      int r;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero size, one byte, exact and just over a block
      alloc(16'd0);
      alloc(16'd1);
      alloc(16'd256);
      alloc(16'd257);
      // free of a run's second block and of a free block
      release_run(6'd4);
      release_run(6'd10);
      // more blocks than the pool, then the whole pool while partly used
      alloc(16'hFFFF);
      alloc(16'd16385);
      alloc(16'd16384);
      // a hole is refilled first
      release_run(6'd1);
      alloc(16'd0);
      release_run(6'd0);
      release_run(6'd1);
      release_run(6'd2);
      release_run(6'd3);
      // whole pool in one run, then a full pool
      alloc(16'd16384);
      alloc(16'd0);
      release_run(6'd0);
      // run up to the last block, no room for two, the last block alone
      alloc(16'd16128);
      alloc(16'd300);
      alloc(16'd1);
      release_run(6'd63);
      release_run(6'd0);
      drain();

      // random churn: real runs freed most of the time, some noise indexes
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) burst = ($urandom_range(3) == 0);
         if (n % 150 == 149) drain();
         r = $urandom_range(99);
         if (r < 45) begin
            alloc(pick_size());
         end else if (r < 88) begin
            live = sb.pick_live_start();
            release_run(live < 0 ? 6'($urandom_range(63)) : 6'(live));
         end else begin
            release_run(6'($urandom_range(63)));
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.errors += sb.pending();
      $display("allocations granted %0d refused %0d, frees done %0d rejected %0d",
               sb.alloc_ok, sb.alloc_refused, sb.free_ok, sb.free_rejected);
      $display("%0d results compared, fewest free blocks seen %0d", sb.checked, sb.min_free);
      if (sb.errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/cba_pkg.sv
rtl/core/cba_ram.sv
rtl/core/cba_size_div.sv
rtl/core/cba_engine.sv
rtl/core/contiguous_block_allocator.sv
test/testbench.sv
